@@ rtl/fpdp_pkg.sv @@
// Package for the Q15 multiply-accumulate block: register indexes, widths,
// clamp limits and the control structs shared by the modules.
// No dependencies.
`default_nettype none

package fpdp_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_SUBTRACT = 2'd0,
    REG_SATURATE = 2'd1,
    REG_KEEP_HALF = 2'd2,
    REG_UNUSED   = 2'd3
  } cfg_reg_e;

  // Saturation limits of the 31-bit range
  localparam logic [AccW-1:0] AccMax31 = 32'h3FFF_FFFF;
  localparam logic [AccW-1:0] AccMin31 = 32'hC000_0000;

  // Mode bits seen by the datapath
  typedef struct packed {
    logic subtract_mode;
    logic saturate_mode;
    logic keep_half;
  } cfg_t;

  // One captured input word
  typedef struct packed {
    logic signed [SampleW-1:0] sample_a;
    logic signed [SampleW-1:0] sample_b;
    logic                      has_product;
    logic signed [AccW-1:0]    initial_acc;
    logic                      first;
    logic                      last;
  } item_t;

endpackage : fpdp_pkg

`default_nettype wire

@@ rtl/fpdp_cfg_regs.sv @@
// Mode register file for the Q15 multiply-accumulate block.
// Depends on fpdp_pkg.
`default_nettype none

module fpdp_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fpdp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fpdp_pkg::CfgDatW-1:0]   cfg_data_i,
  output fpdp_pkg::cfg_t                      cfg_o
);
  import fpdp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e idx;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign idx         = cfg_reg_e'(cfg_index_i);

  // decode one register write per word
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (idx)
        REG_SUBTRACT:  cfg_d.subtract_mode = cfg_data_i[0];
        REG_SATURATE:  cfg_d.saturate_mode = cfg_data_i[0];
        REG_KEEP_HALF: cfg_d.keep_half     = cfg_data_i[0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : fpdp_cfg_regs

`default_nettype wire

@@ rtl/fpdp_mac_step.sv @@
// One accumulate step: load, 16x16 multiply, add or subtract, clamp,
// and the final doubling for the result word unless keep_half is set. Purely combinational.
// Depends on fpdp_pkg.
`default_nettype none

module fpdp_mac_step (
  input  wire fpdp_pkg::item_t             item_i,
  input  wire fpdp_pkg::cfg_t              cfg_i,
  input  wire logic [fpdp_pkg::AccW-1:0]   acc_i,
  output logic [fpdp_pkg::AccW-1:0]        acc_o,
  output logic [fpdp_pkg::AccW-1:0]        result_o
);
  import fpdp_pkg::*;

  logic        [AccW-1:0] base;
  logic signed [AccW-1:0] prod;
  logic        [AccW-1:0] sum;
  logic                   over_hi, over_lo;

  // start of run loads initial value halved (arithmetic shift)
  assign base = item_i.first ? {item_i.initial_acc[AccW-1], item_i.initial_acc[AccW-1:1]}
                             : acc_i;

  // full product always fits in 32 bits
  assign prod = AccW'(item_i.sample_a) * AccW'(item_i.sample_b);

  // wrapping add or subtract
  assign sum = cfg_i.subtract_mode ? (base - AccW'(prod)) : (base + AccW'(prod));

  // outside the 31-bit range when the top two bits differ
  assign over_hi = !sum[AccW-1] &&  sum[AccW-2];
  assign over_lo =  sum[AccW-1] && !sum[AccW-2];

  always_comb begin
    acc_o = base;
    if (item_i.has_product) begin
      acc_o = sum;
      if (cfg_i.saturate_mode && over_hi) begin
        acc_o = AccMax31;
      end else if (cfg_i.saturate_mode && over_lo) begin
        acc_o = AccMin31;
      end
    end
  end

  // doubling drops the top bit
  assign result_o = cfg_i.keep_half ? acc_o : {acc_o[AccW-2:0], 1'b0};

endmodule : fpdp_mac_step

`default_nettype wire

@@ rtl/fixed_point_dot_product_mac.sv @@
// Top level of the streaming Q15 multiply-accumulate block: input register,
// accumulator, output register and handshakes.
// Depends on fpdp_pkg, fpdp_cfg_regs and fpdp_mac_step.
`default_nettype none

// Channel   Direction  Handshake               Words
// in        sink       in_valid_i / in_stall_o  sample pair, flags, initial_acc
// out       source     out_valid_o / out_stall_i  result
// cfg       sink       cfg_valid_i / cfg_ready_o  register index, data
//
// One word per cycle sustained unless a stalled result holds back a last word.
// A word is held in the input register, then the multiply-add-clamp updates
// the accumulator; a last word also writes its result to the output register.
// Reset clears the modes, the accumulator and both valid flags.
// A stalled result only holds back a last word; other words keep flowing.

module fixed_point_dot_product_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input words
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [fpdp_pkg::SampleW-1:0] sample_a_i,
  input  wire logic signed [fpdp_pkg::SampleW-1:0] sample_b_i,
  input  wire logic                                has_product_i,
  input  wire logic signed [fpdp_pkg::AccW-1:0]    initial_acc_i,
  input  wire logic                                first_i,
  input  wire logic                                last_i,
  // result words
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [fpdp_pkg::AccW-1:0]         result_o,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [fpdp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [fpdp_pkg::CfgDatW-1:0]        cfg_data_i
);
  import fpdp_pkg::*;

  cfg_t            cfg;
  item_t           item_q;
  logic            item_vld_q, item_vld_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] res_q, res_d;
  logic            out_vld_q, out_vld_d;
  logic [AccW-1:0] step_acc, step_res;
  logic            in_take, advance;

  fpdp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fpdp_mac_step u_step (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .acc_i    (acc_q),
    .acc_o    (step_acc),
    .result_o (step_res)
  );

  // a held word moves on unless it needs the output slot and that is blocked
  assign advance    = item_vld_q && (!item_q.last || !out_vld_q || !out_stall_i);
  assign in_stall_o = item_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register valid
  always_comb begin
    item_vld_d = item_vld_q;
    if (in_take) begin
      item_vld_d = 1'b1;
    end else if (advance) begin
      item_vld_d = 1'b0;
    end
  end

  // accumulator
  assign acc_d = advance ? step_acc : acc_q;

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (advance && item_q.last) begin
      out_vld_d = 1'b1;
      res_d     = step_res;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      acc_q      <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
      acc_q      <= acc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.sample_a    <= sample_a_i;
      item_q.sample_b    <= sample_b_i;
      item_q.has_product <= has_product_i;
      item_q.initial_acc <= initial_acc_i;
      item_q.first       <= first_i;
      item_q.last        <= last_i;
    end
    res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

endmodule : fixed_point_dot_product_mac

`default_nettype wire
